// File: hdl/tcts_pkg.sv
// ----------------------------------------------------------------------------
// tcts_pkg
// Shared widths, register indexes and types of the charge-time touch sensor.
// ----------------------------------------------------------------------------
package tcts_pkg;

  localparam int SettleW  = 10;
  localparam int TimeoutW = 16;
  localparam int ThreshW  = 16;
  localparam int SmoothW  = 7;
  localparam int ElapsedW = 17;

  localparam int InDataW  = 8;
  localparam int OutDataW = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSettle  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThresh  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSmooth  = 2'd3;

  // Completion event handed from the sequencer to the debounce logic.
  typedef struct packed {
    logic                done;
    logic [ElapsedW-1:0] elapsed;
  } tcts_meas_t;

endpackage

// File: hdl/touch_charge_time_sensor.sv
// ----------------------------------------------------------------------------
// touch_charge_time_sensor
// RC charge-time capacitive touch sensor, one timer tick per input item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  in_     | sink      | tdata[0] sense_level, tdata[1] start_req
//  out_    | source    | tdata[0] drive, [1] busy, [2] done, [3] touched, [20:4] rise
//  cfg_    | sink      | cfg_index selects the register, cfg_wdata is written
//
// One item is taken every clock cycle while the output does not stall; each
// gives one result. The tick passes an input register, then the sequencer and
// debounce update their state as the result register loads. A stall on the
// output holds the result and the input register, and ready falls only when
// both are full. Reset clears state and loads the default configuration.
// ----------------------------------------------------------------------------
module touch_charge_time_sensor #(
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tcts_pkg::InDataW-1:0]     in_tdata,   // sense_level, start_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcts_pkg::OutDataW-1:0]    out_tdata,  // drive_level, busy_res,
                                                       // done_res, touched, rise_ticks
  input  logic                             cfg_wr_en,
  input  logic [tcts_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tcts_pkg::CfgDataW-1:0]    cfg_wdata
);
  import tcts_pkg::*;

  logic [SettleW-1:0]  settle_ticks_r;
  logic [TimeoutW-1:0] timeout_ticks_r;
  logic [ThreshW-1:0]  touch_threshold_r;
  logic [SmoothW-1:0]  smooth_count_r;

  logic                in_valid_r;
  logic                sense_r;
  logic                start_r;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                advance;

  logic                drive_nxt;
  logic                busy_nxt;
  logic                touched_nxt;
  logic [ElapsedW-1:0] rise_nxt;
  tcts_meas_t          meas;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r    <= 10'd10;
      timeout_ticks_r   <= 16'd1000;
      touch_threshold_r <= 16'd50;
      smooth_count_r    <= 7'd3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegSettle:  settle_ticks_r    <= cfg_wdata[SettleW-1:0];
        RegTimeout: timeout_ticks_r   <= cfg_wdata[TimeoutW-1:0];
        RegThresh:  touch_threshold_r <= cfg_wdata[ThreshW-1:0];
        RegSmooth:  smooth_count_r    <= cfg_wdata[SmoothW-1:0];
        default: ;
      endcase
    end
  end

  // The held tick is processed when the result register is free or being emptied.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sense_r <= in_tdata[0];
      start_r <= in_tdata[1];
    end
  end

  tcts_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (advance),
    .sense         (sense_r),
    .start         (start_r),
    .settle_ticks  (settle_ticks_r),
    .timeout_ticks (timeout_ticks_r),
    .drive_nxt     (drive_nxt),
    .busy_nxt      (busy_nxt),
    .meas          (meas)
  );

  tcts_debounce u_debounce (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (advance),
    .meas            (meas),
    .touch_threshold (touch_threshold_r),
    .smooth_count    (smooth_count_r),
    .touched_nxt     (touched_nxt),
    .rise_nxt        (rise_nxt)
  );

  assign out_data_nxt = {3'b000, rise_nxt, touched_nxt, meas.done, busy_nxt, drive_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A completed measurement leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> !out_tdata[1])
    else $error("done reported while still busy");

  // The rise is measured with the excitation pin high, and it stays high afterwards.
  a_done_drive_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> out_tdata[0])
    else $error("done reported with drive low");

  // An empty input register always takes a new tick.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input stalled with empty input register");

endmodule

// File: hdl/tcts_seq.sv
// ----------------------------------------------------------------------------
// tcts_seq
// Measurement sequencer: settle, drive low, wait low, settle, drive high,
// then count the rise time of the sense pin.
// ----------------------------------------------------------------------------
module tcts_seq #(
  parameter int TIMER_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               sense,
  input  logic                               start,
  input  logic [tcts_pkg::SettleW-1:0]       settle_ticks,
  input  logic [tcts_pkg::TimeoutW-1:0]      timeout_ticks,
  output logic                               drive_nxt,
  output logic                               busy_nxt,
  output tcts_pkg::tcts_meas_t               meas
);
  import tcts_pkg::*;

  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhSettleLo = 3'd1;
  localparam logic [2:0] PhWaitLo   = 3'd2;
  localparam logic [2:0] PhSettleHi = 3'd3;
  localparam logic [2:0] PhWaitHi   = 3'd4;

  // The wait count saturates here; above 16 timer bits only the count width limits it.
  localparam logic [ElapsedW-1:0] ElapsedCap =
    (TIMER_BITS >= ElapsedW) ? {ElapsedW{1'b1}} : ElapsedW'(64'd1 << TIMER_BITS);

  logic [2:0]          phase_r, phase_nxt;
  logic [SettleW-1:0]  settle_cnt_r, settle_cnt_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;
  logic                drive_r;
  logic [ElapsedW-1:0] elapsed_inc;
  logic                wait_end;
  logic                target;
  logic                done;

  assign target      = (phase_r == PhWaitHi);
  assign elapsed_inc = (elapsed_r < ElapsedCap) ? elapsed_r + 1'b1 : elapsed_r;

  always_comb begin
    phase_nxt      = phase_r;
    settle_cnt_nxt = settle_cnt_r;
    elapsed_nxt    = elapsed_r;
    drive_nxt      = drive_r;
    done           = 1'b0;
    wait_end       = 1'b0;
    case (phase_r)
      PhIdle: begin
        if (start) begin
          settle_cnt_nxt = '0;
          phase_nxt      = PhSettleLo;
        end
      end
      PhSettleLo, PhSettleHi: begin
        if (settle_cnt_r >= settle_ticks) begin
          drive_nxt   = (phase_r == PhSettleHi);
          elapsed_nxt = '0;
          phase_nxt   = (phase_r == PhSettleHi) ? PhWaitHi : PhWaitLo;
        end else begin
          settle_cnt_nxt = settle_cnt_r + 1'b1;
        end
      end
      PhWaitLo, PhWaitHi: begin
        if (sense == target) begin
          wait_end = 1'b1;
        end else begin
          elapsed_nxt = elapsed_inc;
          wait_end    = (elapsed_inc > {1'b0, timeout_ticks}) || (elapsed_inc >= ElapsedCap);
        end
        if (wait_end) begin
          if (phase_r == PhWaitLo) begin
            settle_cnt_nxt = '0;
            phase_nxt      = PhSettleHi;
          end else begin
            done      = 1'b1;
            phase_nxt = PhIdle;
          end
        end
      end
      default: phase_nxt = PhIdle;
    endcase
  end

  assign busy_nxt     = (phase_nxt != PhIdle);
  assign meas.done    = done;
  assign meas.elapsed = elapsed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PhIdle;
      settle_cnt_r <= '0;
      elapsed_r    <= '0;
      drive_r      <= 1'b0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      settle_cnt_r <= settle_cnt_nxt;
      elapsed_r    <= elapsed_nxt;
      drive_r      <= drive_nxt;
    end
  end

endmodule

// File: hdl/tcts_debounce.sv
// ----------------------------------------------------------------------------
// tcts_debounce
// Classifies each completed rise time and filters the reported touch state.
// ----------------------------------------------------------------------------
module tcts_debounce (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  tcts_pkg::tcts_meas_t           meas,
  input  logic [tcts_pkg::ThreshW-1:0]   touch_threshold,
  input  logic [tcts_pkg::SmoothW-1:0]   smooth_count,
  output logic                           touched_nxt,
  output logic [tcts_pkg::ElapsedW-1:0]  rise_nxt
);
  import tcts_pkg::*;

  logic                touched_r;
  logic [SmoothW-1:0]  mismatch_r, mismatch_nxt, mismatch_inc;
  logic [ElapsedW-1:0] rise_r;
  logic                raw;

  // A zero rise time means the pin was already high, which is taken as a touch.
  assign raw          = (meas.elapsed > {1'b0, touch_threshold}) || (meas.elapsed == '0);
  assign mismatch_inc = (mismatch_r != {SmoothW{1'b1}}) ? mismatch_r + 1'b1 : mismatch_r;

  always_comb begin
    touched_nxt  = touched_r;
    mismatch_nxt = mismatch_r;
    rise_nxt     = rise_r;
    if (meas.done) begin
      rise_nxt = meas.elapsed;
      if (raw == touched_r) begin
        mismatch_nxt = '0;
      end else begin
        mismatch_nxt = mismatch_inc;
        if (mismatch_inc >= smooth_count) begin
          touched_nxt = raw;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r  <= 1'b0;
      mismatch_r <= '0;
      rise_r     <= '0;
    end else if (en) begin
      touched_r  <= touched_nxt;
      mismatch_r <= mismatch_nxt;
      rise_r     <= rise_nxt;
    end
  end

endmodule

// File: tb/tb_touch_charge_time_sensor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_charge_time_sensor
// Self-checking testbench for the RC charge-time touch sensor.
//
// A simple pin model drives the sense input so that the pin follows the
// excitation level after a chosen lag. Every accepted tick is run through a
// local model of the sequencer and debounce logic, and each result item is
// checked field by field against the oldest prediction. Directed tests cover
// the reset settings, long and zero settling, the timeout limits, zero rise
// time, the threshold boundary, the debounce counter at its top value and
// back-pressure. A random phase then follows, with random settings and pin
// lags, noise on the sense pin and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_touch_charge_time_sensor;
  import tcts_pkg::*;

  localparam int TimerBits   = 16;
  localparam int ElapsedCap  = (TimerBits >= 17) ? 'h1FFFF : (1 << TimerBits);
  localparam int CycleLimit  = 2_000_000;
  localparam int RandomItems = 150;
  localparam int DrainCycles = 4;

  typedef enum logic [2:0] {
    PhIdle,
    PhSettleLow,
    PhWaitLow,
    PhSettleHigh,
    PhWaitHigh
  } seq_phase_t;

  // Laid out exactly as out_tdata.
  typedef struct packed {
    logic [2:0]          pad;
    logic [ElapsedW-1:0] rise;
    logic                touched;
    logic                done;
    logic                busy;
    logic                drive;
  } sensor_status_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  // Local copy of the configuration and of the sensor state.
  logic [SettleW-1:0]  settle_limit  = 10'd10;
  logic [TimeoutW-1:0] timeout_limit = 16'd1000;
  logic [ThreshW-1:0]  touch_limit   = 16'd50;
  logic [SmoothW-1:0]  smooth_limit  = 7'd3;

  seq_phase_t          seq_phase    = PhIdle;
  logic [SettleW-1:0]  settle_cnt   = '0;
  int                  charge_ticks = 0;
  logic                drive_lvl    = 1'b0;
  logic                report_touch = 1'b0;
  logic [SmoothW-1:0]  miss_cnt     = '0;
  logic [ElapsedW-1:0] last_rise    = '0;

  // Ticks since the excitation level last changed, as seen by the pin model.
  int pin_since = 1000;

  sensor_status_t status_q[$];

  int   items_sent    = 0;
  int   results_seen  = 0;
  int   fail_count    = 0;
  int   cycle_count   = 0;
  int   hold_request  = 0;
  logic tx_idle_on    = 1'b1;
  logic rx_idle_on    = 1'b1;

  touch_charge_time_sensor #(
    .TIMER_BITS(TimerBits)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sensor model
  // --------------------------------------------------------------------------
  function automatic logic charge_wait_over(logic sense, logic target);
    if (sense == target) return 1'b1;
    if (charge_ticks < ElapsedCap) charge_ticks++;
    return (charge_ticks > timeout_limit) || (charge_ticks >= ElapsedCap);
  endfunction

  task automatic advance_sensor(input logic sense, input logic start);
    sensor_status_t status;
    logic           done;
    logic           raw;
    logic           prev_drive;
    done       = 1'b0;
    prev_drive = drive_lvl;
    case (seq_phase)
      PhIdle: begin
        if (start) begin
          settle_cnt = '0;
          seq_phase  = PhSettleLow;
        end
      end
      PhSettleLow: begin
        if (settle_cnt >= settle_limit) begin
          drive_lvl    = 1'b0;
          charge_ticks = 0;
          seq_phase    = PhWaitLow;
        end else begin
          settle_cnt = settle_cnt + 1'b1;
        end
      end
      PhWaitLow: begin
        if (charge_wait_over(sense, 1'b0)) begin
          settle_cnt = '0;
          seq_phase  = PhSettleHigh;
        end
      end
      PhSettleHigh: begin
        if (settle_cnt >= settle_limit) begin
          drive_lvl    = 1'b1;
          charge_ticks = 0;
          seq_phase    = PhWaitHigh;
        end else begin
          settle_cnt = settle_cnt + 1'b1;
        end
      end
      PhWaitHigh: begin
        if (charge_wait_over(sense, 1'b1)) begin
          // A zero rise time means the pin was already high: treat as touched.
          raw       = (charge_ticks > touch_limit) || (charge_ticks == 0);
          last_rise = ElapsedW'(charge_ticks);
          if (raw == report_touch) begin
            miss_cnt = '0;
          end else begin
            if (miss_cnt < 7'd127) miss_cnt = miss_cnt + 1'b1;
            if (miss_cnt >= smooth_limit) report_touch = raw;
          end
          seq_phase = PhIdle;
          done      = 1'b1;
        end
      end
      default: seq_phase = PhIdle;
    endcase
    pin_since = (drive_lvl != prev_drive) ? 0 : pin_since + 1;

    status.pad     = '0;
    status.rise    = last_rise;
    status.touched = report_touch;
    status.done    = done;
    status.busy    = (seq_phase != PhIdle);
    status.drive   = drive_lvl;
    status_q.push_back(status);
  endtask

  // The sense pin follows the excitation level after the given lag in ticks.
  function automatic logic pin_level(int fall_lag, int rise_lag);
    if (drive_lvl) return (pin_since >= rise_lag);
    return !(pin_since >= fall_lag);
  endfunction

  // --------------------------------------------------------------------------
  // Input channel and configuration port
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic sense, input logic start);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= InDataW'({start, sense});
    do @(posedge clk); while (!in_tready);
    advance_sensor(sense, start);
    items_sent++;
  endtask

  task automatic settle_down();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      RegSettle:  settle_limit  = value[SettleW-1:0];
      RegTimeout: timeout_limit = value[TimeoutW-1:0];
      RegThresh:  touch_limit   = value[ThreshW-1:0];
      RegSmooth:  smooth_limit  = value[SmoothW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int settle, input int timeout, input int thresh,
                           input int smooth);
    settle_down();
    write_reg(RegSettle, CfgDataW'(settle));
    write_reg(RegTimeout, CfgDataW'(timeout));
    write_reg(RegThresh, CfgDataW'(thresh));
    write_reg(RegSmooth, CfgDataW'(smooth));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One full measurement; start requests during the sequence must be ignored.
  task automatic run_measurement(input int fall_lag, input int rise_lag, input int noise_pct);
    logic sense;
    send_tick(pin_level(fall_lag, rise_lag), 1'b1);
    while (seq_phase != PhIdle) begin
      sense = pin_level(fall_lag, rise_lag);
      if ($urandom_range(1, 100) <= noise_pct) sense = ~sense;
      send_tick(sense, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (hold_request > 0) begin
        stall        = stall + hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    sensor_status_t got;
    sensor_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (status_q.size() == 0) begin
        report_failure($sformatf("result %0d: unexpected item %h", results_seen, out_tdata));
      end else begin
        want = status_q.pop_front();
        if (got.drive !== want.drive || got.busy !== want.busy || got.done !== want.done ||
            got.touched !== want.touched || got.rise !== want.rise || got.pad !== want.pad)
          report_failure({
            $sformatf("result %0d: expected drive %0b busy %0b done %0b touched %0b",
                      results_seen, want.drive, want.busy, want.done, want.touched),
            $sformatf(" rise %0d pad %0h, got drive %0b busy %0b done %0b touched %0b",
                      want.rise, want.pad, got.drive, got.busy, got.done, got.touched),
            $sformatf(" rise %0d pad %0h", got.rise, got.pad)});
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Registers at their reset values: a slow rise must be seen three times in a
  // row before the report changes.
  task automatic test_reset_settings();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    idle_ticks(4);
    repeat (3) run_measurement(2, 60, 0);
    repeat (2) run_measurement(1, 20, 0);
  endtask

  task automatic test_settle_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    configure(40, 200, 10, 1);
    run_measurement(3, 15, 0);
    configure(0, 200, 10, 1);
    run_measurement(0, 5, 0);
    run_measurement(2, 12, 0);
  endtask

  task automatic test_timeouts();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // The pin never follows: both waits run out after two ticks.
    configure(0, 1, 0, 1);
    run_measurement(1000, 1000, 0);
    run_measurement(0, 1000, 0);
    // Longest timeout with a slow but finite rise.
    configure(2, 65535, 100, 1);
    run_measurement(5, 120, 0);
    configure(1, 65535, 65535, 1);
    run_measurement(0, 150, 0);
  endtask

  task automatic test_zero_rise();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    configure(1, 50, 65535, 1);
    run_measurement(0, 0, 0);
    run_measurement(0, 7, 0);
    run_measurement(0, 0, 0);
  endtask

  // A rise equal to the threshold is not a touch, one tick more is.
  task automatic test_threshold_edges();
    configure(0, 300, 20, 1);
    run_measurement(0, 20, 0);
    run_measurement(0, 21, 0);
    run_measurement(0, 20, 0);
    configure(0, 300, 0, 2);
    run_measurement(0, 1, 0);
    run_measurement(0, 1, 0);
  endtask

  // 131 touch samples in a row after an untouched report: the counter must reach
  // its top value and the report flip only on the 127th.
  task automatic test_debounce_saturation();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    configure(0, 20, 65535, 1);
    run_measurement(0, 3, 0);
    configure(0, 20, 65535, 127);
    repeat (131) run_measurement(0, 0, 0);
    repeat (2) run_measurement(0, 3, 0);
    run_measurement(0, 0, 0);
  endtask

  // The receiver holds off for a long stretch so that the block fills and
  // drops in_tready while ticks keep being offered.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    configure(0, 100, 30, 2);
    hold_request = 300;
    run_measurement(2, 40, 0);
    idle_ticks(20);
    run_measurement(1, 10, 0);
  endtask

  task automatic pick_random_settings();
    int settle;
    int timeout;
    int thresh;
    int smooth;
    int r;
    r = $urandom_range(0, 19);
    settle = (r == 0) ? 40 : (r < 4) ? 0 : $urandom_range(0, 12);
    r = $urandom_range(0, 9);
    timeout = (r == 0) ? 1 : (r == 1) ? 65535 : $urandom_range(1, 200);
    r = $urandom_range(0, 9);
    thresh = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 120);
    r = $urandom_range(0, 9);
    smooth = (r == 0) ? 127 : (r == 1) ? 1 : $urandom_range(1, 4);
    configure(settle, timeout, thresh, smooth);
  endtask

  task automatic test_random();
    int first_item;
    int runs;
    int fall_lag;
    int rise_lag;
    int noise;
    int r;
    first_item = items_sent;
    while (items_sent - first_item < RandomItems) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      pick_random_settings();
      runs = $urandom_range(3, 10);
      repeat (runs) begin
        fall_lag = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 5);
        r = $urandom_range(0, 9);
        if (r == 0) begin
          rise_lag = 0;
        end else if (r < 4) begin
          rise_lag = int'(touch_limit) + $urandom_range(0, 4) - 2;
        end else begin
          rise_lag = $urandom_range(0, (timeout_limit + 5 < 150) ? timeout_limit + 5 : 150);
        end
        if (rise_lag < 0) rise_lag = 0;
        if (rise_lag > 150) rise_lag = 150;
        noise = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : 0;
        run_measurement(fall_lag, rise_lag, noise);
        idle_ticks($urandom_range(0, 5));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_settle_extremes();
    test_timeouts();
    test_zero_rise();
    test_threshold_edges();
    test_debounce_saturation();
    test_backpressure();
    test_random();

    settle_down();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: touch_charge_time_sensor.f
hdl/tcts_pkg.sv
hdl/tcts_seq.sv
hdl/tcts_debounce.sv
hdl/touch_charge_time_sensor.sv
tb/tb_touch_charge_time_sensor.sv
